FILE: rtl/core/clean_speaker_embedding_select_assert.svh
`ifndef CLEAN_SPEAKER_EMBEDDING_SELECT_ASSERT_SVH
`define CLEAN_SPEAKER_EMBEDDING_SELECT_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define CSES_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define CSES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/cses_pkg.sv
package cses_pkg;

	localparam logic [1:0] CMD_FRAME = 2'd0;
	localparam logic [1:0] CMD_EMBED = 2'd1;
	localparam logic [1:0] CMD_END   = 2'd2;

	localparam int MASK_W   = 4;
	localparam int SLOT_W   = 2;
	localparam int WORD_W   = 32;
	localparam int CHUNK_W  = 16;
	localparam int ACTIVE_W = 3;
	localparam int MIN_W    = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic REG_ACTIVE = 1'b0;
	localparam logic REG_MIN    = 1'b1;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd3;

	typedef enum logic [1:0] {
		OP_FRAME,
		OP_NAN,
		OP_END
	} cses_op_t;

	typedef struct packed {
		cses_op_t          op;
		logic [SLOT_W-1:0] slot;
	} cses_entry_t;

	typedef struct packed {
		logic [ACTIVE_W-1:0] active_speakers;
		logic [MIN_W-1:0]    min_clean_frames;
	} cses_cfg_t;

	typedef struct packed {
		logic        valid;
		cses_entry_t entry;
	} cses_head_t;

endpackage

FILE: rtl/core/clean_speaker_embedding_select.sv
// Channel   Role        Handshake                  Payload
// s_*       items in    s_tvalid / s_tready        tuser command, tdata mask/slot/word
// m_*       results     m_tvalid / m_tready        tdata chunk/speaker, tlast last
// apb       registers   psel / penable / pready    active_speakers, min_clean_frames
//
// Frame and embedding items stream one per cycle while the queue is not full.
// End of chunk is handled in the back end, whose output register then emits one result
// per kept speaker, one result per cycle while the output is not stalled.
// A four-entry queue parts the input side from the counter update and emission.
// Reset is asynchronous and clears counters, flags, chunk index and queue.
// A stalled output holds the next end of chunk at the queue head, and the entries
// behind it; s_tready drops only when the queue is full.
module clean_speaker_embedding_select #(
	parameter int MAX_SPEAKERS = 4,
	parameter int COUNT_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // activity_mask[3:0], speaker_slot[5:4], embedding_bits[37:6]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // chunk_index[15:0], speaker_index[17:16]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cses_pkg::cses_cfg_t   cfg_q;
	logic                  queue_full;
	logic                  push;
	cses_pkg::cses_entry_t push_entry;
	cses_pkg::cses_head_t  head;
	logic                  pop;
	logic [cses_pkg::CHUNK_W-1:0] out_chunk;
	logic [cses_pkg::SLOT_W-1:0]  out_slot;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_speakers  <= cses_pkg::ACTIVE_RESET;
			cfg_q.min_clean_frames <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				cses_pkg::REG_ACTIVE: cfg_q.active_speakers  <= pwdata[cses_pkg::ACTIVE_W-1:0];
				cses_pkg::REG_MIN:    cfg_q.min_clean_frames <= pwdata[cses_pkg::MIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			cses_pkg::REG_ACTIVE: prdata = {29'b0, cfg_q.active_speakers};
			cses_pkg::REG_MIN:    prdata = {16'b0, cfg_q.min_clean_frames};
			default:              prdata = '0;
		endcase
	end

	cses_front #(
		.MAX_SPEAKERS(MAX_SPEAKERS)
	) u_front (
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.command        (s_tuser),
		.activity_mask  (s_tdata[3:0]),
		.speaker_slot   (s_tdata[5:4]),
		.embedding_bits (s_tdata[37:6]),
		.active_speakers(cfg_q.active_speakers),
		.queue_full     (queue_full),
		.push           (push),
		.push_entry     (push_entry)
	);

	cses_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (queue_full),
		.head      (head),
		.pop       (pop)
	);

	cses_back #(
		.MAX_SPEAKERS(MAX_SPEAKERS),
		.COUNT_BITS  (COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_chunk(out_chunk),
		.out_slot (out_slot),
		.out_last (m_tlast)
	);

	assign m_tdata = {6'b0, out_slot, out_chunk};

endmodule

FILE: rtl/core/cses_front.sv
module cses_front #(
	parameter int MAX_SPEAKERS = 4
) (
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [1:0]                       command,
	input  logic [cses_pkg::MASK_W-1:0]      activity_mask,
	input  logic [cses_pkg::SLOT_W-1:0]      speaker_slot,
	input  logic [cses_pkg::WORD_W-1:0]      embedding_bits,
	input  logic [cses_pkg::ACTIVE_W-1:0]    active_speakers,
	input  logic                             queue_full,
	output logic                             push,
	output cses_pkg::cses_entry_t            push_entry
);

	logic [cses_pkg::MASK_W-1:0] use_mask;
	logic [cses_pkg::MASK_W-1:0] clean_mask;
	logic [cses_pkg::SLOT_W-1:0] frame_slot;
	logic                        word_nan;
	logic                        keep;

	always_comb begin
		for (int k = 0; k < cses_pkg::MASK_W; k++) begin
			use_mask[k] = (k < MAX_SPEAKERS) &&
				(cses_pkg::ACTIVE_W'(k) < active_speakers);
		end
		clean_mask = activity_mask & use_mask;
		frame_slot = '0;
		for (int k = cses_pkg::MASK_W - 1; k >= 0; k--) begin
			if (clean_mask[k]) begin
				frame_slot = cses_pkg::SLOT_W'(k);
			end
		end
	end

	assign word_nan = (embedding_bits[30:23] == 8'hFF) && (embedding_bits[22:0] != '0);

	always_comb begin
		keep       = 1'b0;
		push_entry = '{op: cses_pkg::OP_END, slot: speaker_slot};
		unique case (command)
			cses_pkg::CMD_FRAME: begin
				keep       = $onehot(clean_mask);
				push_entry = '{op: cses_pkg::OP_FRAME, slot: frame_slot};
			end
			cses_pkg::CMD_EMBED: begin
				keep       = word_nan && (int'(speaker_slot) < MAX_SPEAKERS);
				push_entry = '{op: cses_pkg::OP_NAN, slot: speaker_slot};
			end
			cses_pkg::CMD_END: begin
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign s_tready = !queue_full;
	assign push     = s_tvalid && !queue_full && keep;

endmodule

FILE: rtl/core/cses_queue.sv
module cses_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  cses_pkg::cses_entry_t push_entry,
	output logic                  full,
	output cses_pkg::cses_head_t  head,
	input  logic                  pop
);

	cses_pkg::cses_entry_t           entry_q [cses_pkg::QUEUE_DEPTH];
	logic [cses_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [cses_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [cses_pkg::QPTR_W:0]       count_q;

	assign full       = (count_q == (cses_pkg::QPTR_W + 1)'(cses_pkg::QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/cses_back.sv
module cses_back #(
	parameter int MAX_SPEAKERS = 4,
	parameter int COUNT_BITS   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cses_pkg::cses_cfg_t            cfg,
	input  cses_pkg::cses_head_t           head,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cses_pkg::CHUNK_W-1:0]   out_chunk,
	output logic [cses_pkg::SLOT_W-1:0]    out_slot,
	output logic                           out_last
);

	localparam int IDX_W = (MAX_SPEAKERS > 1) ? $clog2(MAX_SPEAKERS) : 1;
	localparam int CMP_W = (COUNT_BITS > cses_pkg::MIN_W) ? COUNT_BITS : cses_pkg::MIN_W;

	logic [COUNT_BITS-1:0]        cnt_q [MAX_SPEAKERS];
	logic [MAX_SPEAKERS-1:0]      nan_q;
	logic [MAX_SPEAKERS-1:0]      keep_q;
	logic [cses_pkg::CHUNK_W-1:0] chunk_q;
	logic [cses_pkg::CHUNK_W-1:0] emit_chunk_q;
	logic                         out_valid_q;
	logic [cses_pkg::CHUNK_W-1:0] out_chunk_q;
	logic [cses_pkg::SLOT_W-1:0]  out_slot_q;
	logic                         out_last_q;

	logic [MAX_SPEAKERS-1:0] keep_d;
	logic [MAX_SPEAKERS-1:0] keep_rest;
	logic [IDX_W-1:0]        pick;
	logic                    emit_go;
	logic                    pop_end;

	always_comb begin
		for (int s = 0; s < MAX_SPEAKERS; s++) begin
			keep_d[s] = (s < int'(cfg.active_speakers)) && !nan_q[s] &&
				(CMP_W'(cnt_q[s]) >= CMP_W'(cfg.min_clean_frames));
		end
		pick = '0;
		for (int s = MAX_SPEAKERS - 1; s >= 0; s--) begin
			if (keep_q[s]) begin
				pick = IDX_W'(s);
			end
		end
	end

	assign keep_rest = keep_q & (keep_q - 1'b1);
	assign emit_go   = (keep_q != '0) && (!out_valid_q || out_ready);
	assign pop       = head.valid && ((head.entry.op != cses_pkg::OP_END) || (keep_q == '0));
	assign pop_end   = pop && (head.entry.op == cses_pkg::OP_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_SPEAKERS; s++) begin
				cnt_q[s] <= '0;
			end
			nan_q        <= '0;
			keep_q       <= '0;
			chunk_q      <= '0;
			emit_chunk_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				unique case (head.entry.op)
					cses_pkg::OP_FRAME: begin
						for (int s = 0; s < MAX_SPEAKERS; s++) begin
							if ((int'(head.entry.slot) == s) && (cnt_q[s] != '1)) begin
								cnt_q[s] <= cnt_q[s] + COUNT_BITS'(1);
							end
						end
					end
					cses_pkg::OP_NAN: begin
						for (int s = 0; s < MAX_SPEAKERS; s++) begin
							if (int'(head.entry.slot) == s) begin
								nan_q[s] <= 1'b1;
							end
						end
					end
					cses_pkg::OP_END: begin
						for (int s = 0; s < MAX_SPEAKERS; s++) begin
							cnt_q[s] <= '0;
						end
						nan_q        <= '0;
						emit_chunk_q <= chunk_q;
						chunk_q      <= chunk_q + 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (pop_end) begin
				keep_q <= keep_d;
			end else if (emit_go) begin
				keep_q <= keep_rest;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_chunk_q <= emit_chunk_q;
			out_slot_q  <= cses_pkg::SLOT_W'(pick);
			out_last_q  <= (keep_rest == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_chunk = out_chunk_q;
	assign out_slot  = out_slot_q;
	assign out_last  = out_last_q;

endmodule

FILE: rtl/core/cses_checker.sv
`include "clean_speaker_embedding_select_assert.svh"

module cses_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast,
	input logic        pready
);

	`CSES_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
	`CSES_ASSERT_NEXT(a_burst_cont, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap inside a chunk's results")
	`CSES_ASSERT_NEXT(a_burst_chunk, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tdata[15:0] == $past(m_tdata[15:0]), "chunk index changed inside a chunk")
	`CSES_ASSERT(a_pad_zero, clk, arst_n, !m_tvalid || (m_tdata[23:18] == 6'b0), "nonzero padding in result")
	`CSES_ASSERT(a_pready_high, clk, arst_n, pready, "pready dropped")

endmodule

bind clean_speaker_embedding_select cses_checker u_cses_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.pready  (pready)
);

FILE: sim/clean_speaker_embedding_select_tb.sv
module clean_speaker_embedding_select_tb;

	localparam int WATCH_LIMIT = 4000;
	localparam int SETTLE      = 16;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic [cses_pkg::CHUNK_W-1:0] chunk;
		logic [cses_pkg::SLOT_W-1:0]  spk;
		logic                         last;
	} pick_t;

	typedef struct {
		bit                           pinned;
		logic [3:0]                   keep;
		logic [cses_pkg::CHUNK_W-1:0] chunk;
	} keep_tag_t;

	typedef struct {
		bit                           is_cfg;
		logic                         ridx;
		logic [31:0]                  rval;
		logic [1:0]                   cmd;
		logic [cses_pkg::MASK_W-1:0]  mask;
		logic [cses_pkg::SLOT_W-1:0]  slot;
		logic [cses_pkg::WORD_W-1:0]  word;
		bit                           pinned;
		logic [3:0]                   keep;
		logic [cses_pkg::CHUNK_W-1:0] chunk;
	} plan_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	logic [cses_pkg::ACTIVE_W-1:0] cfg_active = cses_pkg::ACTIVE_RESET;
	logic [cses_pkg::MIN_W-1:0]    cfg_min    = '0;
	logic [15:0]                   clean_count [4] = '{default: '0};
	logic [3:0]                    nan_seen   = '0;
	logic [cses_pkg::CHUNK_W-1:0]  chunk_now  = '0;

	pick_t     due_picks [$];
	keep_tag_t keep_tags [$];
	bit        calm         = 1'b0;
	int        errors       = 0;
	int        checked      = 0;
	int        stall_cycles = 0;

	clean_speaker_embedding_select dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void track_item(input logic [1:0] cmd, input logic [3:0] mask,
			input logic [1:0] slot, input logic [31:0] word, input bit publish);
		int         n_use;
		int         last_s;
		logic [3:0] use_mask;
		logic [3:0] m;
		logic [3:0] kept;
		n_use = (cfg_active > 3'd4) ? 4 : int'(cfg_active);
		use_mask = 4'((5'd1 << n_use) - 5'd1);
		if (cmd == cses_pkg::CMD_FRAME) begin
			m = mask & use_mask;
			if (m != 4'd0 && (m & (m - 4'd1)) == 4'd0) begin
				for (int k = 0; k < 4; k++)
					if (m[k] && clean_count[k] != 16'hFFFF)
						clean_count[k] = clean_count[k] + 16'd1;
			end
		end else if (cmd == cses_pkg::CMD_EMBED) begin
			if (word[30:23] == 8'hFF && word[22:0] != 23'd0)
				nan_seen[slot] = 1'b1;
		end else if (cmd == cses_pkg::CMD_END) begin
			kept = '0;
			last_s = -1;
			for (int s = 0; s < n_use; s++) begin
				if (clean_count[s] >= cfg_min && !nan_seen[s]) begin
					kept[s] = 1'b1;
					last_s = s;
				end
			end
			if (publish) begin
				for (int s = 0; s < 4; s++)
					if (kept[s])
						due_picks.insert(due_picks.size(), {chunk_now, 2'(s), s == last_s});
			end
			for (int k = 0; k < 4; k++)
				clean_count[k] = '0;
			nan_seen = '0;
			chunk_now = chunk_now + 16'd1;
		end
	endfunction

	always @(posedge clk) begin : watch_ports
		keep_tag_t tag;
		pick_t     got;
		pick_t     want;
		int        top;
		if (arst_n && s_tvalid && s_tready) begin
			tag = keep_tags.pop_front();
			track_item(s_tuser, s_tdata[3:0], s_tdata[5:4], s_tdata[37:6], !tag.pinned);
			if (tag.pinned) begin
				top = -1;
				for (int k = 0; k < 4; k++)
					if (tag.keep[k])
						top = k;
				for (int k = 0; k < 4; k++)
					if (tag.keep[k])
						due_picks.insert(due_picks.size(), {tag.chunk, 2'(k), k == top});
			end
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[15:0], m_tdata[17:16], m_tlast};
			if (due_picks.size() == 0) begin
				errors++;
				$display("%0t unexpected result: chunk %0d speaker %0d last %0b",
					$time, got.chunk, got.spk, got.last);
			end else begin
				want = due_picks.pop_front();
				checked++;
				if (got.chunk !== want.chunk || got.spk !== want.spk ||
						got.last !== want.last) begin
					errors++;
					$display("%0t mismatch: expected chunk %0d speaker %0d last %0b,",
						$time, want.chunk, want.spk, want.last,
						" got chunk %0d speaker %0d last %0b",
						got.chunk, got.spk, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 37);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable && pready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCH_LIMIT) begin
				$display("%0t watchdog: no transfer for %0d cycles, %0d results outstanding",
					$time, WATCH_LIMIT, due_picks.size());
				$display("FAIL clean_speaker_embedding_select");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [1:0] cmd, input logic [3:0] mask,
			input logic [1:0] slot, input logic [31:0] word, input bit pinned,
			input logic [3:0] keep, input logic [15:0] chunk);
		keep_tag_t tag;
		tag.pinned = pinned;
		tag.keep = keep;
		tag.chunk = chunk;
		while (!calm && $urandom_range(99) < 37) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		keep_tags.insert(keep_tags.size(), tag);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {2'b00, word, slot, mask};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (due_picks.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [31:0] value);
		logic [31:0] want;
		want = (idx == cses_pkg::REG_ACTIVE) ? {29'd0, value[2:0]} : {16'd0, value[15:0]};
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == cses_pkg::REG_ACTIVE)
			cfg_active = value[2:0];
		else
			cfg_min = value[15:0];
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== want) begin
			errors++;
			$display("%0t register readback at %0d: expected %h, got %h",
				$time, {idx, 2'b00}, want, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic plan_row_t item_row(input logic [1:0] cmd, input logic [3:0] mask,
			input logic [1:0] slot, input logic [31:0] word);
		plan_row_t r;
		r.is_cfg = 1'b0;
		r.ridx = cses_pkg::REG_ACTIVE;
		r.rval = '0;
		r.cmd = cmd;
		r.mask = mask;
		r.slot = slot;
		r.word = word;
		r.pinned = 1'b0;
		r.keep = '0;
		r.chunk = '0;
		return r;
	endfunction

	function automatic plan_row_t end_row(input logic [3:0] keep, input logic [15:0] chunk);
		plan_row_t r;
		r = item_row(cses_pkg::CMD_END, 4'h0, 2'd0, 32'h0);
		r.pinned = 1'b1;
		r.keep = keep;
		r.chunk = chunk;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input logic idx, input logic [31:0] value);
		plan_row_t r;
		r = item_row(cses_pkg::CMD_FRAME, 4'h0, 2'd0, 32'h0);
		r.is_cfg = 1'b1;
		r.ridx = idx;
		r.rval = value;
		return r;
	endfunction

	initial begin : stimulus
		plan_row_t   plan [$];
		int          items_sent;
		int          chunks;
		int          len;
		int          r;
		logic [1:0]  cmd;
		logic [3:0]  mask;
		logic [1:0]  slot;
		logic [31:0] word;
		logic [31:0] v;

		items_sent = 0;
		chunks = 0;

		plan.insert(plan.size(), end_row(4'b0111, 16'd0));
		plan.insert(plan.size(), item_row(cses_pkg::CMD_FRAME, 4'b0001, 2'd0, 32'h0));
		plan.insert(plan.size(), item_row(cses_pkg::CMD_FRAME, 4'b0011, 2'd0, 32'h0));
		plan.insert(plan.size(), item_row(cses_pkg::CMD_FRAME, 4'b1000, 2'd0, 32'h0));
		plan.insert(plan.size(), item_row(cses_pkg::CMD_EMBED, 4'h0, 2'd1, 32'h7FC0_0000));
		plan.insert(plan.size(), item_row(cses_pkg::CMD_EMBED, 4'h0, 2'd2, 32'h7F80_0000));
		plan.insert(plan.size(), item_row(cses_pkg::CMD_EMBED, 4'h0, 2'd3, 32'h7FC0_0000));
		plan.insert(plan.size(), end_row(4'b0101, 16'd1));
		plan.insert(plan.size(), cfg_row(cses_pkg::REG_MIN, 32'd1));
		plan.insert(plan.size(), item_row(cses_pkg::CMD_FRAME, 4'b0100, 2'd0, 32'h0));
		plan.insert(plan.size(), item_row(cses_pkg::CMD_EMBED, 4'h0, 2'd0, 32'hFFFF_FFFF));
		plan.insert(plan.size(), end_row(4'b0100, 16'd2));
		plan.insert(plan.size(), cfg_row(cses_pkg::REG_ACTIVE, 32'd0));
		plan.insert(plan.size(), item_row(cses_pkg::CMD_FRAME, 4'b0001, 2'd0, 32'h0));
		plan.insert(plan.size(), end_row(4'b0000, 16'd3));
		plan.insert(plan.size(), cfg_row(cses_pkg::REG_ACTIVE, 32'd7));
		plan.insert(plan.size(), cfg_row(cses_pkg::REG_MIN, 32'd0));
		plan.insert(plan.size(), item_row(cses_pkg::CMD_EMBED, 4'h0, 2'd3, 32'h0000_0001));
		plan.insert(plan.size(), item_row(cses_pkg::CMD_EMBED, 4'h0, 2'd2, 32'hFF80_0001));
		plan.insert(plan.size(), item_row(CMD_SPARE, 4'hF, 2'd1, 32'h7FC0_0000));
		plan.insert(plan.size(), end_row(4'b1011, 16'd4));
		plan.insert(plan.size(), cfg_row(cses_pkg::REG_MIN, 32'h0000_FFFF));
		plan.insert(plan.size(), item_row(cses_pkg::CMD_FRAME, 4'b1000, 2'd0, 32'h0));
		plan.insert(plan.size(), end_row(4'b0000, 16'd5));
		plan.insert(plan.size(), cfg_row(cses_pkg::REG_ACTIVE, 32'd1));
		plan.insert(plan.size(), cfg_row(cses_pkg::REG_MIN, 32'd1));
		plan.insert(plan.size(), item_row(cses_pkg::CMD_FRAME, 4'b1111, 2'd0, 32'h0));
		plan.insert(plan.size(), item_row(cses_pkg::CMD_FRAME, 4'b0010, 2'd0, 32'h0));
		plan.insert(plan.size(), end_row(4'b0001, 16'd6));
		plan.insert(plan.size(), cfg_row(cses_pkg::REG_ACTIVE, 32'd4));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle_block();
				reg_write(plan[i].ridx, plan[i].rval);
			end else begin
				send_item(plan[i].cmd, plan[i].mask, plan[i].slot, plan[i].word,
					plan[i].pinned, plan[i].keep, plan[i].chunk);
				if (plan[i].cmd != CMD_SPARE)
					items_sent++;
				if (plan[i].cmd == cses_pkg::CMD_END)
					chunks++;
			end
		end

		while (items_sent < 130) begin
			calm <= (items_sent >= 60 && items_sent < 95);
			if ($urandom_range(2) == 0) begin
				settle_block();
				v = ($urandom & 32'hFFFF_FFF8) |
					(($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(4, 1));
				reg_write(cses_pkg::REG_ACTIVE, v);
				r = $urandom_range(9);
				if (r < 5)
					v = $urandom_range(3);
				else if (r < 7)
					v = 0;
				else if (r == 7)
					v = 32'h0000_FFFF;
				else
					v = $urandom_range(65535);
				reg_write(cses_pkg::REG_MIN, ($urandom & 32'hFFFF_0000) | v);
			end
			len = $urandom_range(12);
			for (int j = 0; j < len; j++) begin
				mask = 4'($urandom_range(15));
				slot = 2'($urandom_range(3));
				word = $urandom;
				r = $urandom_range(99);
				if (r < 55) begin
					cmd = cses_pkg::CMD_FRAME;
					if ($urandom_range(1) == 0)
						mask = 4'b0001 << $urandom_range(3);
				end else if (r < 90) begin
					cmd = cses_pkg::CMD_EMBED;
					case ($urandom_range(3))
						0: begin
							word = {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(8388607, 1))};
						end
						1: begin
							word = {1'($urandom_range(1)), 8'hFF, 23'd0};
						end
						default: begin
						end
					endcase
				end else begin
					cmd = CMD_SPARE;
				end
				send_item(cmd, mask, slot, word, 1'b0, 4'h0, 16'h0);
				if (cmd != CMD_SPARE)
					items_sent++;
			end
			send_item(cses_pkg::CMD_END, 4'($urandom_range(15)), 2'($urandom_range(3)), $urandom,
				1'b0, 4'h0, 16'h0);
			items_sent++;
			chunks++;
		end

		settle_block();
		$display("Covered %0d directed and random items over %0d chunks, %0d results checked,",
			items_sent, chunks, checked);
		$display("with register changes between chunks and random stalls on both sides.");
		if (errors == 0)
			$display("PASS clean_speaker_embedding_select");
		else
			$display("FAIL clean_speaker_embedding_select");
		$finish;
	end

endmodule
